>>> rtl/json_token_lexer_defines.svh
// Assertion helpers used by the lexer controller.
`ifndef JSON_TOKEN_LEXER_DEFINES_SVH
`define JSON_TOKEN_LEXER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define JTL_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define JTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/jtl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jtl_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KIND_W    = 4;
  localparam int unsigned OUT_IDX_W = 5;
  localparam int unsigned OUT_LEN_W = 6;

  localparam logic [BYTE_W-1:0] CH_LBRACE   = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE   = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_COLON    = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACKET = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_COMMA    = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_QUOTE    = 8'h22;
  localparam logic [BYTE_W-1:0] CH_DOT      = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_MINUS    = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF       = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_ZERO     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE     = 8'h39;
  localparam logic [BYTE_W-1:0] CH_NUL      = 8'h00;

  typedef enum logic [KIND_W-1:0] {
    KIND_LBRACE   = 4'd0,
    KIND_RBRACE   = 4'd1,
    KIND_COLON    = 4'd2,
    KIND_LBRACKET = 4'd3,
    KIND_RBRACKET = 4'd4,
    KIND_COMMA    = 4'd5,
    KIND_IDENT    = 4'd6,
    KIND_VALUE    = 4'd7,
    KIND_END      = 4'd8,
    KIND_ERROR    = 4'd9
  } token_kind_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_IDENT = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } lex_phase_e;

  typedef enum logic [1:0] {
    ST_TAKE,
    ST_READ,
    ST_SEND,
    ST_RESTART
  } ctrl_state_e;

  typedef struct packed {
    token_kind_e            kind;
    logic [BYTE_W-1:0]      char_byte;
    logic [OUT_IDX_W-1:0]   char_index;
    logic [OUT_LEN_W-1:0]   token_length;
    logic                   last;
  } out_beat_t;

  function automatic logic is_blank(input logic [BYTE_W-1:0] b);
    return (b == CH_TAB) || (b == CH_LF) || (b == CH_CR) || (b == CH_SPACE);
  endfunction

  function automatic logic is_value_char(input logic [BYTE_W-1:0] b);
    return ((b >= CH_ZERO) && (b <= CH_NINE)) || (b == CH_DOT) || (b == CH_MINUS);
  endfunction

  function automatic logic is_single(input logic [BYTE_W-1:0] b);
    return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_COLON) ||
           (b == CH_LBRACKET) || (b == CH_RBRACKET) || (b == CH_COMMA);
  endfunction

  function automatic token_kind_e single_kind(input logic [BYTE_W-1:0] b);
    token_kind_e k;
    case (b)
      CH_LBRACE:   k = KIND_LBRACE;
      CH_RBRACE:   k = KIND_RBRACE;
      CH_COLON:    k = KIND_COLON;
      CH_LBRACKET: k = KIND_LBRACKET;
      CH_RBRACKET: k = KIND_RBRACKET;
      CH_COMMA:    k = KIND_COMMA;
      default:     k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

>>> rtl/jtl_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module jtl_buf
  import jtl_pkg::*;
#(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [BYTE_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // hold read data between reads
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/jtl_outreg.sv
`timescale 1ns / 1ps
`default_nettype none

module jtl_outreg
  import jtl_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      ld_i,
  input  wire out_beat_t beat_i,
  output      logic      slot_free_o,
  output      logic      out_valid_o,
  input  wire logic      out_ready_i,
  output      out_beat_t beat_o
);

  logic      valid_q, valid_d;
  out_beat_t beat_q;

  assign slot_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ld_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      beat_q <= beat_i;
    end
  end

  assign out_valid_o = valid_q;
  assign beat_o      = beat_q;

endmodule

`default_nettype wire

>>> rtl/jtl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module jtl_ctrl
  import jtl_pkg::*;
#(
  parameter int unsigned MAX_TOKEN_CHARS = 32,
  parameter int unsigned IDX_W = $clog2(MAX_TOKEN_CHARS),
  parameter int unsigned CNT_W = $clog2(MAX_TOKEN_CHARS + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [BYTE_W-1:0] in_byte_i,
  input  wire logic              end_of_input_i,
  output      logic              in_ready_o,
  input  wire logic              slot_free_i,
  output      logic              out_ld_o,
  output      out_beat_t         out_beat_o,
  output      logic              mem_we_o,
  output      logic [IDX_W-1:0]  mem_waddr_o,
  output      logic [BYTE_W-1:0] mem_wdata_o,
  output      logic              mem_re_o,
  output      logic [IDX_W-1:0]  mem_raddr_o,
  input  wire logic [BYTE_W-1:0] mem_rdata_i
);

  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_TOKEN_CHARS);
  localparam logic [CNT_W-1:0] CNT_VMAX = CNT_W'(MAX_TOKEN_CHARS - 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  ctrl_state_e       state_q, state_d;
  lex_phase_e        phase_q, phase_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  len_q, len_d;
  token_kind_e       kind_q, kind_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic [BYTE_W-1:0] pend_q, pend_d;

  logic [BYTE_W-1:0] src_byte;
  logic              step_en;
  logic              is_end;
  logic              go_emit;
  logic              emit_last;

  assign src_byte  = (state_q == ST_RESTART) ? pend_q : in_byte_i;
  assign in_ready_o = (state_q == ST_TAKE) && slot_free_i;
  assign step_en   = ((state_q == ST_TAKE) && in_valid_i && slot_free_i) ||
                     ((state_q == ST_RESTART) && slot_free_i);
  assign is_end    = (state_q == ST_TAKE) && (end_of_input_i || (in_byte_i == CH_NUL));
  assign emit_last = ((CNT_W'(rd_idx_q) + CNT_ONE) == len_q);

  // byte processing, emission and memory access
  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    len_d       = len_q;
    kind_d      = kind_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = pend_q;
    go_emit     = 1'b0;
    out_ld_o    = 1'b0;
    out_beat_o  = '{kind: KIND_ERROR, char_byte: src_byte, char_index: '0,
                    token_length: OUT_LEN_W'(1), last: 1'b1};
    mem_we_o    = 1'b0;
    mem_waddr_o = count_q[IDX_W-1:0];
    mem_wdata_o = src_byte;
    mem_re_o    = (state_q == ST_READ);
    mem_raddr_o = rd_idx_q;

    if (step_en && (phase_q != PH_DONE)) begin
      if (is_end) begin
        out_ld_o   = 1'b1;
        out_beat_o = '{kind: KIND_END, char_byte: '0, char_index: '0,
                       token_length: '0, last: 1'b1};
        phase_d    = PH_DONE;
        count_d    = '0;
      end else if (!is_blank(src_byte)) begin
        case (phase_q)
          PH_IDENT: begin
            if (count_q >= CNT_MAX) begin
              out_ld_o = 1'b1;
              phase_d  = PH_IDLE;
              count_d  = '0;
            end else begin
              mem_we_o = 1'b1;
              count_d  = count_q + CNT_ONE;
              if (src_byte == CH_QUOTE) begin
                go_emit = 1'b1;
                kind_d  = KIND_IDENT;
                len_d   = count_q + CNT_ONE;
                phase_d = PH_IDLE;
                count_d = '0;
              end
            end
          end
          PH_VALUE: begin
            if (is_value_char(src_byte)) begin
              if (count_q >= CNT_VMAX) begin
                out_ld_o = 1'b1;
                phase_d  = PH_IDLE;
                count_d  = '0;
              end else begin
                mem_we_o = 1'b1;
                count_d  = count_q + CNT_ONE;
              end
            end else begin
              // flush the value, then restart on this byte
              go_emit = 1'b1;
              kind_d  = KIND_VALUE;
              len_d   = count_q;
              pend_d  = src_byte;
              phase_d = PH_IDLE;
              count_d = '0;
            end
          end
          default: begin
            if (is_single(src_byte)) begin
              out_ld_o        = 1'b1;
              out_beat_o.kind = single_kind(src_byte);
            end else if ((src_byte == CH_QUOTE) || is_value_char(src_byte)) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = '0;
              count_d     = CNT_ONE;
              phase_d     = (src_byte == CH_QUOTE) ? PH_IDENT : PH_VALUE;
            end else begin
              out_ld_o = 1'b1;
              count_d  = '0;
            end
          end
        endcase
      end
    end

    if (go_emit) begin
      rd_idx_d = '0;
    end

    if ((state_q == ST_SEND) && slot_free_i) begin
      out_ld_o   = 1'b1;
      out_beat_o = '{kind: kind_q, char_byte: mem_rdata_i,
                     char_index: OUT_IDX_W'(rd_idx_q),
                     token_length: OUT_LEN_W'(len_q), last: emit_last};
      rd_idx_d   = emit_last ? '0 : rd_idx_q + IDX_W'(1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_TAKE: begin
        if (go_emit) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_SEND;
      ST_SEND: begin
        if (slot_free_i) begin
          if (!emit_last) begin
            state_d = ST_READ;
          end else if (kind_q == KIND_VALUE) begin
            state_d = ST_RESTART;
          end else begin
            state_d = ST_TAKE;
          end
        end
      end
      ST_RESTART: begin
        if (slot_free_i) begin
          state_d = ST_TAKE;
        end
      end
      default: state_d = ST_TAKE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_TAKE;
      phase_q  <= PH_IDLE;
      count_q  <= '0;
      kind_q   <= KIND_END;
      rd_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      count_q  <= count_d;
      kind_q   <= kind_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    pend_q <= pend_d;
  end

`include "json_token_lexer_defines.svh"

  `JTL_ASSERT_HOLDS(a_ld_free, clk_i, rst_ni, out_ld_o, slot_free_i, "output load into a busy slot")
  `JTL_ASSERT_HOLDS(a_rd_range, clk_i, rst_ni, state_q == ST_READ, CNT_W'(rd_idx_q) < len_q, "buffer read past token length")
  `JTL_ASSERT_NEXT(a_done_sticky, clk_i, rst_ni, phase_q == PH_DONE, phase_q == PH_DONE, "lexer left the done phase")
  `JTL_ASSERT_HOLDS(a_wr_range, clk_i, rst_ni, mem_we_o, count_q < CNT_MAX, "buffer write beyond capacity")

endmodule

`default_nettype wire

>>> rtl/json_token_lexer.sv
`timescale 1ns / 1ps
`default_nettype none

// JSON token lexer: one text byte per input beat, one result beat per token
// character. Whitespace is dropped, punctuation and bad bytes produce a single
// beat in the cycle after the byte is taken, and identifier and value
// characters collect in a MAX_TOKEN_CHARS-byte buffer RAM. A finished token
// is replayed from that RAM one character at a time: a synchronous read, then
// a load of the output register, which waits while the output slot is busy.
// A value that is ended by another byte handles that byte afterward, in a
// restart step once its last character is loaded. The input is not ready
// during replay. While a result beat waits in the output register the input
// is held off as well, except in the cycle in which that beat is taken. After
// a zero byte or end_of_input the end beat is sent and all further input is
// swallowed until reset. No clearing pass is needed after reset.
module json_token_lexer
  import jtl_pkg::*;
#(
  parameter int unsigned MAX_TOKEN_CHARS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire logic [BYTE_W-1:0]    in_byte_i,
  input  wire logic                 end_of_input_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      logic [KIND_W-1:0]    token_kind_o,
  output      logic [BYTE_W-1:0]    char_byte_o,
  output      logic [OUT_IDX_W-1:0] char_index_o,
  output      logic [OUT_LEN_W-1:0] token_length_o,
  output      logic                 last_o
);

  localparam int unsigned IDX_W = $clog2(MAX_TOKEN_CHARS);
  localparam int unsigned CNT_W = $clog2(MAX_TOKEN_CHARS + 1);

  logic              slot_free;
  logic              out_ld;
  out_beat_t         ld_beat;
  out_beat_t         out_beat;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  jtl_ctrl #(
    .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS),
    .IDX_W           (IDX_W),
    .CNT_W           (CNT_W)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .in_ready_o     (in_ready_o),
    .slot_free_i    (slot_free),
    .out_ld_o       (out_ld),
    .out_beat_o     (ld_beat),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  jtl_buf #(
    .DEPTH  (MAX_TOKEN_CHARS),
    .ADDR_W (IDX_W)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  jtl_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_i        (out_ld),
    .beat_i      (ld_beat),
    .slot_free_o (slot_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .beat_o      (out_beat)
  );

  assign token_kind_o   = out_beat.kind;
  assign char_byte_o    = out_beat.char_byte;
  assign char_index_o   = out_beat.char_index;
  assign token_length_o = out_beat.token_length;
  assign last_o         = out_beat.last;

endmodule

`default_nettype wire
